FILE: hdl/awb_otp_gain_calc_defines.svh
// Assertion macros for the white-balance gain calculation block.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef AWB_OTP_GAIN_CALC_DEFINES_SVH
`define AWB_OTP_GAIN_CALC_DEFINES_SVH

`ifndef SYNTHESIS
`define AWB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define AWB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AWB_ASSERT_SAME(lbl, ante, cons, msg)
`define AWB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/awb_pkg.sv
package awb_pkg;

	localparam int FW = 16;
	localparam int UNITY_GAIN_DEF = 256;
	localparam logic [FW-1:0] GAIN_MAX = 16'hFFFF;

	localparam logic [FW-1:0] RST_EXP_ID   = 16'h0001;
	localparam logic [FW-1:0] RST_TYP_RED  = 16'h0246;
	localparam logic [FW-1:0] RST_TYP_BLUE = 16'h0261;

	typedef enum logic [1:0] {
		REG_EXP_ID   = 2'd0,
		REG_TYP_RED  = 2'd1,
		REG_TYP_BLUE = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_ID_MISMATCH = 2'd1,
		ST_ZERO_RATIO  = 2'd2
	} status_t;

	// sideband carried through the first divider pair
	typedef struct packed {
		logic [FW-1:0] mr;
		logic [FW-1:0] mb;
		logic [FW-1:0] tr;
		logic [FW-1:0] tb;
		status_t       status;
		logic          mb_lt;
		logic          mr_lt;
	} side1_t;

	// sideband carried through the second divider pair
	typedef struct packed {
		logic [FW-1:0] g_gain;
		status_t       status;
		logic          pin_r;
		logic          pin_b;
	} side2_t;

endpackage

FILE: hdl/awb_otp_gain_calc.sv
// White-balance gain calibration from a camera module's OTP ratios.
// Input channel: in_valid / in_stall carry red_ratio, blue_ratio and otp_id;
// a transfer happens at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry red_gain, green_gain, blue_gain
// and status, one result per input transfer, in order.
// Configuration: cfg_wr_en writes cfg_data into the register cfg_index
// (0 expected module id, 1 typical R/G, 2 typical B/G); other indexes are dropped.
// Write registers only while the pipeline holds no item.
// Pipeline: an entry register, then the two chained restoring dividers, one quotient bit
// per stage: PW stages for the first pair and 16 for the second, PW = clog2(UNITY_GAIN+1)+16,
// with select and multiply registers between them and an output register at the end.
// Throughput: one transfer per cycle in each direction while no result waits under out_stall.
// Stall: when out_stall holds a waiting result, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset: arst_n clears all valid bits and loads the register defaults
// (id 1, typical ratios 582 and 609).
`include "awb_otp_gain_calc_defines.svh"

module awb_otp_gain_calc #(
	parameter int UNITY_GAIN = awb_pkg::UNITY_GAIN_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [1:0]             cfg_index,
	input  logic [awb_pkg::FW-1:0] cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [awb_pkg::FW-1:0] red_ratio,
	input  logic [awb_pkg::FW-1:0] blue_ratio,
	input  logic [awb_pkg::FW-1:0] otp_id,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [awb_pkg::FW-1:0] red_gain,
	output logic [awb_pkg::FW-1:0] green_gain,
	output logic [awb_pkg::FW-1:0] blue_gain,
	output logic [1:0]             status
);

	localparam int FW = awb_pkg::FW;
	localparam int UW = $clog2(UNITY_GAIN + 1);
	// width of unity times a ratio, and of the exact first quotient
	localparam int PW = UW + FW;
	localparam logic [PW:0]   UNITY_N  = (PW+1)'(UNITY_GAIN);
	localparam logic [FW-1:0] UNITY_16 = FW'(UNITY_GAIN);

	logic adv;

	logic [FW-1:0] exp_id_q, typ_red_q, typ_blue_q;

	logic            v_s1;
	awb_pkg::side1_t side_s1;
	awb_pkg::side1_t side_in;
	awb_pkg::status_t st_in;

	logic [1:0][PW:0]   d1_num;
	logic [1:0][FW-1:0] d1_den;
	logic               d1_valid;
	logic [1:0][PW-1:0] d1_quo;
	logic [1:0]         d1_ovf;
	logic [$bits(awb_pkg::side1_t)-1:0] d1_side;
	awb_pkg::side1_t    d1_side_t;

	logic                    m_valid;
	logic [1:0][PW+FW-1:0]   m_num;
	logic [1:0][FW-1:0]      m_den;
	awb_pkg::side2_t         m_side;

	logic               d2_valid;
	logic [1:0][FW-1:0] d2_quo;
	logic [1:0]         d2_ovf;
	logic [$bits(awb_pkg::side2_t)-1:0] d2_side;
	awb_pkg::side2_t    d2_side_t;

	logic [FW-1:0] r_fin, b_fin;

	// Freeze every stage while a finished result waits at the output.
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_id_q   <= awb_pkg::RST_EXP_ID;
			typ_red_q  <= awb_pkg::RST_TYP_RED;
			typ_blue_q <= awb_pkg::RST_TYP_BLUE;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				awb_pkg::REG_EXP_ID:   exp_id_q   <= cfg_data;
				awb_pkg::REG_TYP_RED:  typ_red_q  <= cfg_data;
				awb_pkg::REG_TYP_BLUE: typ_blue_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Entry stage: status and branch flags; id mismatch wins over zero ratios.
	always_comb begin
		if (otp_id != exp_id_q) begin
			st_in = awb_pkg::ST_ID_MISMATCH;
		end else if (red_ratio == '0 || blue_ratio == '0 || typ_red_q == '0
				|| typ_blue_q == '0) begin
			st_in = awb_pkg::ST_ZERO_RATIO;
		end else begin
			st_in = awb_pkg::ST_OK;
		end
		side_in.mr     = red_ratio;
		side_in.mb     = blue_ratio;
		side_in.tr     = typ_red_q;
		side_in.tb     = typ_blue_q;
		side_in.status = st_in;
		side_in.mb_lt  = blue_ratio < typ_blue_q;
		side_in.mr_lt  = red_ratio < typ_red_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_in;
		end
	end

	// First divider pair: unity * measured / typical for red and blue.
	// One spare high bit keeps the quotient exact over all PW bits.
	assign d1_num[0] = UNITY_N * (PW+1)'(side_s1.mr);
	assign d1_num[1] = UNITY_N * (PW+1)'(side_s1.mb);
	assign d1_den[0] = side_s1.tr;
	assign d1_den[1] = side_s1.tb;

	awb_div #(
		.NW(PW + 1),
		.QW(PW),
		.SW($bits(awb_pkg::side1_t))
	) u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s1),
		.num      (d1_num),
		.den      (d1_den),
		.side_in  (side_s1),
		.out_valid(d1_valid),
		.quo      (d1_quo),
		.ovf      (d1_ovf),
		.side_out (d1_side)
	);

	assign d1_side_t = awb_pkg::side1_t'(d1_side);

	// Pick the pinned channel, then form gain * typical for the second pair.
	awb_mul #(
		.UNITY_GAIN(UNITY_GAIN),
		.PW(PW)
	) u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (d1_valid),
		.q        (d1_quo),
		.side_in  (d1_side_t),
		.out_valid(m_valid),
		.num      (m_num),
		.den      (m_den),
		.side_out (m_side)
	);

	// Second divider pair: only 16 quotient bits, overflow means saturation.
	awb_div #(
		.NW(PW + FW),
		.QW(FW),
		.SW($bits(awb_pkg::side2_t))
	) u_div2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (m_valid),
		.num      (m_num),
		.den      (m_den),
		.side_in  (m_side),
		.out_valid(d2_valid),
		.quo      (d2_quo),
		.ovf      (d2_ovf),
		.side_out (d2_side)
	);

	assign d2_side_t = awb_pkg::side2_t'(d2_side);

	// Clamp red and blue to [unity, max]; a pinned channel stays at unity.
	always_comb begin
		if (d2_side_t.pin_r) begin
			r_fin = UNITY_16;
		end else if (d2_ovf[0]) begin
			r_fin = awb_pkg::GAIN_MAX;
		end else if (d2_quo[0] < UNITY_16) begin
			r_fin = UNITY_16;
		end else begin
			r_fin = d2_quo[0];
		end
		if (d2_side_t.pin_b) begin
			b_fin = UNITY_16;
		end else if (d2_ovf[1]) begin
			b_fin = awb_pkg::GAIN_MAX;
		end else if (d2_quo[1] < UNITY_16) begin
			b_fin = UNITY_16;
		end else begin
			b_fin = d2_quo[1];
		end
	end

	// Output register; any error status forces unity gains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status <= d2_side_t.status;
			if (d2_side_t.status != awb_pkg::ST_OK) begin
				red_gain   <= UNITY_16;
				green_gain <= UNITY_16;
				blue_gain  <= UNITY_16;
			end else begin
				red_gain   <= r_fin;
				green_gain <= d2_side_t.g_gain;
				blue_gain  <= b_fin;
			end
		end
	end

	// A zero divisor in the first pair must come from an item already flagged.
	`AWB_ASSERT_SAME(a_div1_zero_flagged, d1_valid && (d1_ovf != 2'b00), d1_side_t.status != awb_pkg::ST_OK, "first divider overflow on an item with ok status")
	// Every delivered gain lies at or above unity.
	`AWB_ASSERT_SAME(a_gain_floor, out_valid, red_gain >= UNITY_16 && green_gain >= UNITY_16 && blue_gain >= UNITY_16, "gain below unity")
	// A good result always has one channel pinned at unity.
	`AWB_ASSERT_SAME(a_one_pinned, out_valid && status == awb_pkg::ST_OK, red_gain == UNITY_16 || green_gain == UNITY_16 || blue_gain == UNITY_16, "no channel pinned at unity")
	// A stalled pipeline holds its output result.
	`AWB_ASSERT_NEXT(a_hold_on_stall, out_valid && out_stall, out_valid && $stable(red_gain) && $stable(blue_gain), "result changed under stall")

endmodule

FILE: hdl/awb_div.sv
module awb_div #(
	parameter int NW = 25,
	parameter int QW = 24,
	parameter int SW = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [1:0][NW-1:0]       num,
	input  logic [1:0][awb_pkg::FW-1:0] den,
	input  logic [SW-1:0]            side_in,
	output logic                     out_valid,
	output logic [1:0][QW-1:0]       quo,
	output logic [1:0]               ovf,
	output logic [SW-1:0]            side_out
);

	localparam int HW = NW - QW;
	localparam int CW = (HW > awb_pkg::FW) ? HW : awb_pkg::FW;

	logic                     v_s    [QW];
	logic [SW-1:0]            side_s [QW];
	logic [awb_pkg::FW-1:0]   rem_s  [2][QW];
	logic [QW-1:0]            lq_s   [2][QW];
	logic [awb_pkg::FW-1:0]   den_s  [2][QW];
	logic                     ovf_s  [2][QW];

	logic [awb_pkg::FW-1:0]   rem_p  [2][QW];
	logic [QW-1:0]            lq_p   [2][QW];
	logic [awb_pkg::FW-1:0]   den_p  [2][QW];
	logic                     ovf_p  [2][QW];

	for (genvar k = 0; k < QW; k++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= (k == 0) ? in_valid : v_s[(k == 0) ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= (k == 0) ? side_in : side_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		for (genvar k = 0; k < QW; k++) begin : g_stg
			logic [awb_pkg::FW:0] r2;
			logic                 ge;

			if (k == 0) begin : g_in
				logic [HW-1:0] hi;
				assign hi          = num[l][NW-1:QW];
				// quotient does not fit when the high part already reaches the divisor
				assign ovf_p[l][k] = CW'(hi) >= CW'(den[l]);
				assign rem_p[l][k] = awb_pkg::FW'(hi);
				assign lq_p[l][k]  = num[l][QW-1:0];
				assign den_p[l][k] = den[l];
			end else begin : g_chain
				assign ovf_p[l][k] = ovf_s[l][k-1];
				assign rem_p[l][k] = rem_s[l][k-1];
				assign lq_p[l][k]  = lq_s[l][k-1];
				assign den_p[l][k] = den_s[l][k-1];
			end

			assign r2 = {rem_p[l][k], lq_p[l][k][QW-1]};
			assign ge = r2 >= {1'b0, den_p[l][k]};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[l][k] <= ge ? awb_pkg::FW'(r2 - {1'b0, den_p[l][k]})
						: r2[awb_pkg::FW-1:0];
					lq_s[l][k]  <= {lq_p[l][k][QW-2:0], ge};
					den_s[l][k] <= den_p[l][k];
					ovf_s[l][k] <= ovf_p[l][k];
				end
			end
		end
		assign quo[l] = lq_s[l][QW-1];
		assign ovf[l] = ovf_s[l][QW-1];
	end

	assign out_valid = v_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule

FILE: hdl/awb_mul.sv
module awb_mul #(
	parameter int UNITY_GAIN = awb_pkg::UNITY_GAIN_DEF,
	parameter int PW = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [1:0][PW-1:0]            q,
	input  awb_pkg::side1_t               side_in,
	output logic                          out_valid,
	output logic [1:0][PW+awb_pkg::FW-1:0] num,
	output logic [1:0][awb_pkg::FW-1:0]   den,
	output awb_pkg::side2_t               side_out
);

	localparam int NW = PW + awb_pkg::FW;
	localparam logic [PW-1:0] UNITY_P = PW'(UNITY_GAIN);

	logic [PW-1:0] xr, xb, g;
	logic          pin_r, pin_b;
	logic [awb_pkg::FW-1:0] g_clamp;

	logic                   v_s1;
	logic [PW-1:0]          xr_s1, xb_s1;
	logic [awb_pkg::FW-1:0] tr_s1, tb_s1, mr_s1, mb_s1;
	awb_pkg::side2_t        side_s1;

	logic                   v_s2;
	logic [1:0][NW-1:0]     num_s2;
	logic [1:0][awb_pkg::FW-1:0] den_s2;
	awb_pkg::side2_t        side_s2;

	// q[0] is the red-derived green gain, q[1] the blue-derived one
	always_comb begin
		xr    = UNITY_P;
		xb    = UNITY_P;
		g     = UNITY_P;
		pin_r = 1'b0;
		pin_b = 1'b0;
		if (side_in.mb_lt && side_in.mr_lt) begin
			g = UNITY_P;
		end else if (side_in.mb_lt) begin
			pin_r = 1'b1;
			g     = q[0];
			xb    = q[0];
		end else if (side_in.mr_lt) begin
			pin_b = 1'b1;
			g     = q[1];
			xr    = q[1];
		end else if (q[1] > q[0]) begin
			pin_b = 1'b1;
			g     = q[1];
			xr    = q[1];
		end else begin
			pin_r = 1'b1;
			g     = q[0];
			xb    = q[0];
		end
	end

	always_comb begin
		if (g > PW'(awb_pkg::GAIN_MAX)) begin
			g_clamp = awb_pkg::GAIN_MAX;
		end else if (g < UNITY_P) begin
			g_clamp = awb_pkg::FW'(UNITY_GAIN);
		end else begin
			g_clamp = g[awb_pkg::FW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xr_s1          <= xr;
			xb_s1          <= xb;
			tr_s1          <= side_in.tr;
			tb_s1          <= side_in.tb;
			mr_s1          <= side_in.mr;
			mb_s1          <= side_in.mb;
			side_s1.g_gain <= g_clamp;
			side_s1.status <= side_in.status;
			side_s1.pin_r  <= pin_r;
			side_s1.pin_b  <= pin_b;

			num_s2[0] <= NW'(xr_s1) * NW'(tr_s1);
			num_s2[1] <= NW'(xb_s1) * NW'(tb_s1);
			den_s2[0] <= mr_s1;
			den_s2[1] <= mb_s1;
			side_s2   <= side_s1;
		end
	end

	assign out_valid = v_s2;
	assign num       = num_s2;
	assign den       = den_s2;
	assign side_out  = side_s2;

endmodule
